// ----- design/pgs_pkg.sv -----
// Shared types, constants and arithmetic helpers for the PID gain slew scheduler.
package pgs_pkg;

    typedef enum logic [1:0] {
        MODE_FIXED     = 2'd0,
        MODE_FUZZY     = 2'd1,
        MODE_LEARN     = 2'd2,
        MODE_FIXED_ALT = 2'd3
    } mode_t;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TUNE_MODE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_KP   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_KI   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_KD   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_KP    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_KI    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_KD    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_VALID = 4'd7;

    typedef logic [15:0] gain_t;
    typedef logic [13:0] rate_t;

    // Gain limits in Q3.13.
    localparam gain_t KP_MIN  = 16'd819;
    localparam gain_t KP_MAX  = 16'd49152;
    localparam gain_t KID_MIN = 16'd0;
    localparam gain_t KID_MAX = 16'd16384;

    // Slew rates in Q1.13 per second.
    localparam rate_t KP_RATE = 14'd9830;
    localparam rate_t KI_RATE = 14'd4915;
    localparam rate_t KD_RATE = 14'd6554;

    function automatic gain_t clamp_gain(input gain_t v, input gain_t lo, input gain_t hi);
        gain_t r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Largest move of one tick: rate times tick length, fraction dropped.
    function automatic rate_t slew_step(input rate_t rate, input logic [15:0] dt);
        logic [29:0] p;
        p = {16'd0, rate} * {14'd0, dt};
        return p[29:16];
    endfunction

    // Moves cur toward tgt by at most step, then clamps to lo..hi.
    function automatic gain_t slew_clamp(input gain_t cur, input gain_t tgt, input rate_t step,
                                         input gain_t lo, input gain_t hi);
        logic signed [18:0] c;
        logic signed [18:0] t;
        logic signed [18:0] s;
        logic signed [18:0] up;
        logic signed [18:0] dn;
        logic signed [18:0] r;
        logic signed [18:0] l;
        logic signed [18:0] h;
        gain_t              res;
        c  = signed'({3'b000, cur});
        t  = signed'({3'b000, tgt});
        s  = signed'({5'b00000, step});
        l  = signed'({3'b000, lo});
        h  = signed'({3'b000, hi});
        up = c + s;
        dn = c - s;
        if (t > up)
        begin
            r = up;
        end
        else if (t < dn)
        begin
            r = dn;
        end
        else
        begin
            r = t;
        end
        if (r < l)
        begin
            res = lo;
        end
        else if (r > h)
        begin
            res = hi;
        end
        else
        begin
            res = r[15:0];
        end
        return res;
    endfunction

endpackage

// ----- design/pid_gain_slew_scheduler.sv -----
// Top level of the PID gain slew scheduler: registers, gain slewing and ISE watchdog.
// Each input word is captured in an input register and, when the output side can take
// it, its gains, retrain flag and baseline are computed in a single combinational pass
// and stored in the state registers, which drive the result word directly. One word is
// accepted and one result delivered every clock when the output side is ready, limited
// only by that single update pass on the gain and baseline state. Configuration writes
// are meant to be made only while no word is in flight.
module pid_gain_slew_scheduler
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [15:0]                    fuzzy_kp,
    input  logic [15:0]                    fuzzy_ki,
    input  logic [15:0]                    fuzzy_kd,
    input  logic [15:0]                    time_step,
    input  logic                           perf_valid,
    input  logic [31:0]                    window_ise,
    input  logic                           settled,
    input  logic                           clear_retrain,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [15:0]                    gain_kp,
    output logic [14:0]                    gain_ki,
    output logic [14:0]                    gain_kd,
    output logic                           retrain_request,
    output logic [31:0]                    baseline_ise
);
    import pgs_pkg::*;

    mode_t       tune_mode_reg;
    gain_t       fixed_kp_reg;
    gain_t       fixed_ki_reg;
    gain_t       fixed_kd_reg;
    gain_t       host_kp_reg;
    gain_t       host_ki_reg;
    gain_t       host_kd_reg;
    logic        host_valid_reg;

    logic        s1_valid_reg;
    gain_t       s1_fkp_reg;
    gain_t       s1_fki_reg;
    gain_t       s1_fkd_reg;
    logic [15:0] s1_dt_reg;
    logic        s1_pvalid_reg;
    logic [31:0] s1_ise_reg;
    logic        s1_settled_reg;
    logic        s1_clr_reg;

    logic        out_valid_reg;
    gain_t       active_kp_reg;
    logic [14:0] active_ki_reg;
    logic [14:0] active_kd_reg;
    logic [31:0] baseline_reg;
    logic        retrain_reg;

    logic        advance;
    logic        in_fire;
    logic        cfg_fire;
    logic        fixed_mode;
    logic        fixed_load;
    gain_t       tgt_kp;
    gain_t       tgt_ki;
    gain_t       tgt_kd;
    gain_t       active_kp_next;
    gain_t       active_ki_next;
    gain_t       active_kd_next;
    logic [31:0] baseline_next;
    logic        retrain_next;
    gain_t       load_kp;
    gain_t       load_ki;
    gain_t       load_kd;
    logic [36:0] ise_x20;
    logic [36:0] base_x17;
    logic [34:0] ise_x5;
    logic [34:0] base_x6;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    assign fixed_mode = (tune_mode_reg != MODE_FUZZY) && (tune_mode_reg != MODE_LEARN);
    assign fixed_load = cfg_fire && fixed_mode &&
                        ((cfg_index == CFG_FIXED_KP) || (cfg_index == CFG_FIXED_KI) ||
                         (cfg_index == CFG_FIXED_KD));

    // The fixed set as it stands after this write, clamped for loading.
    always_comb
    begin
        load_kp = clamp_gain((cfg_index == CFG_FIXED_KP) ? cfg_data : fixed_kp_reg,
                             KP_MIN, KP_MAX);
        load_ki = clamp_gain((cfg_index == CFG_FIXED_KI) ? cfg_data : fixed_ki_reg,
                             KID_MIN, KID_MAX);
        load_kd = clamp_gain((cfg_index == CFG_FIXED_KD) ? cfg_data : fixed_kd_reg,
                             KID_MIN, KID_MAX);
    end

    always_comb
    begin
        case (tune_mode_reg)
            MODE_FUZZY:
            begin
                tgt_kp = s1_fkp_reg;
                tgt_ki = s1_fki_reg;
                tgt_kd = s1_fkd_reg;
            end
            MODE_LEARN:
            begin
                tgt_kp = host_valid_reg ? host_kp_reg : s1_fkp_reg;
                tgt_ki = host_valid_reg ? host_ki_reg : s1_fki_reg;
                tgt_kd = host_valid_reg ? host_kd_reg : s1_fkd_reg;
            end
            default:
            begin
                tgt_kp = fixed_kp_reg;
                tgt_ki = fixed_ki_reg;
                tgt_kd = fixed_kd_reg;
            end
        endcase
    end

    always_comb
    begin
        active_kp_next = slew_clamp(active_kp_reg, clamp_gain(tgt_kp, KP_MIN, KP_MAX),
                                    slew_step(KP_RATE, s1_dt_reg), KP_MIN, KP_MAX);
        active_ki_next = slew_clamp({1'b0, active_ki_reg}, clamp_gain(tgt_ki, KID_MIN, KID_MAX),
                                    slew_step(KI_RATE, s1_dt_reg), KID_MIN, KID_MAX);
        active_kd_next = slew_clamp({1'b0, active_kd_reg}, clamp_gain(tgt_kd, KID_MIN, KID_MAX),
                                    slew_step(KD_RATE, s1_dt_reg), KID_MIN, KID_MAX);
    end

    // Thresholds of 0.85 and 1.2 times the baseline, compared exactly.
    always_comb
    begin
        ise_x20  = ({5'd0, s1_ise_reg} << 4) + ({5'd0, s1_ise_reg} << 2);
        base_x17 = ({5'd0, baseline_reg} << 4) + {5'd0, baseline_reg};
        ise_x5   = ({3'd0, s1_ise_reg} << 2) + {3'd0, s1_ise_reg};
        base_x6  = ({3'd0, baseline_reg} << 2) + ({3'd0, baseline_reg} << 1);
        baseline_next = baseline_reg;
        retrain_next  = s1_clr_reg ? 1'b0 : retrain_reg;
        if (s1_pvalid_reg)
        begin
            if ((baseline_reg == 32'd0) && (s1_ise_reg != 32'd0) && s1_settled_reg)
            begin
                baseline_next = s1_ise_reg;
            end
            else if ((baseline_reg != 32'd0) && (ise_x20 < base_x17))
            begin
                baseline_next = s1_ise_reg;
            end
            else if ((baseline_reg != 32'd0) && (ise_x5 > base_x6))
            begin
                retrain_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tune_mode_reg  <= MODE_FIXED;
            fixed_kp_reg   <= '0;
            fixed_ki_reg   <= '0;
            fixed_kd_reg   <= '0;
            host_kp_reg    <= '0;
            host_ki_reg    <= '0;
            host_kd_reg    <= '0;
            host_valid_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            active_kp_reg  <= '0;
            active_ki_reg  <= '0;
            active_kd_reg  <= '0;
            baseline_reg   <= '0;
            retrain_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_TUNE_MODE:  tune_mode_reg  <= mode_t'(cfg_data[1:0]);
                    CFG_FIXED_KP:   fixed_kp_reg   <= cfg_data;
                    CFG_FIXED_KI:   fixed_ki_reg   <= cfg_data;
                    CFG_FIXED_KD:   fixed_kd_reg   <= cfg_data;
                    CFG_HOST_KP:    host_kp_reg    <= cfg_data;
                    CFG_HOST_KI:    host_ki_reg    <= cfg_data;
                    CFG_HOST_KD:    host_kd_reg    <= cfg_data;
                    CFG_HOST_VALID: host_valid_reg <= cfg_data[0];
                    default:        ;
                endcase
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                active_kp_reg <= active_kp_next;
                active_ki_reg <= active_ki_next[14:0];
                active_kd_reg <= active_kd_next[14:0];
                baseline_reg  <= baseline_next;
                retrain_reg   <= retrain_next;
            end
            else if (fixed_load)
            begin
                active_kp_reg <= load_kp;
                active_ki_reg <= load_ki[14:0];
                active_kd_reg <= load_kd[14:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_fkp_reg     <= fuzzy_kp;
            s1_fki_reg     <= fuzzy_ki;
            s1_fkd_reg     <= fuzzy_kd;
            s1_dt_reg      <= time_step;
            s1_pvalid_reg  <= perf_valid;
            s1_ise_reg     <= window_ise;
            s1_settled_reg <= settled;
            s1_clr_reg     <= clear_retrain;
        end
    end

    assign out_valid       = out_valid_reg;
    assign gain_kp         = active_kp_reg;
    assign gain_ki         = active_ki_reg;
    assign gain_kd         = active_kd_reg;
    assign retrain_request = retrain_reg;
    assign baseline_ise    = baseline_reg;

endmodule

// ----- design/pgs_checker.sv -----
// Port-level checker for the PID gain slew scheduler and its bind to the top level.
module pgs_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] gain_kp,
    input  logic [14:0] gain_ki,
    input  logic [14:0] gain_kd,
    input  logic        retrain_request,
    input  logic [31:0] baseline_ise
);

    // A result word that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gain_kp) && $stable(gain_ki) &&
        $stable(gain_kd) && $stable(retrain_request) && $stable(baseline_ise))
    else $error("result word changed while stalled");

    // Every delivered proportional gain lies within its limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gain_kp >= 16'd819) && (gain_kp <= 16'd49152))
    else $error("proportional gain out of range");

    // Every delivered integral and derivative gain lies within its limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gain_ki <= 15'd16384) && (gain_kd <= 15'd16384))
    else $error("integral or derivative gain out of range");

    // The retrain flag is only raised together with a new result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(retrain_request) |-> out_valid)
    else $error("retrain flag raised without a result word");

endmodule

bind pid_gain_slew_scheduler pgs_checker u_pgs_checker (.*);

// ----- verif/pgs_gain_checker.sv -----
// Checker for the PID gain slew scheduler: predicts every result word and compares it.
`timescale 1ns / 100ps

module pgs_gain_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [15:0]                    fuzzy_kp,
    input  logic [15:0]                    fuzzy_ki,
    input  logic [15:0]                    fuzzy_kd,
    input  logic [15:0]                    time_step,
    input  logic                           perf_valid,
    input  logic [31:0]                    window_ise,
    input  logic                           settled,
    input  logic                           clear_retrain,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [15:0]                    gain_kp,
    input  logic [14:0]                    gain_ki,
    input  logic [14:0]                    gain_kd,
    input  logic                           retrain_request,
    input  logic [31:0]                    baseline_ise,
    output int                             fail_count,
    output int                             pending,
    output int                             checked
);

    import pgs_pkg::*;

    typedef struct {
        logic [15:0] kp;
        logic [14:0] ki;
        logic [14:0] kd;
        logic        retrain;
        logic [31:0] baseline;
    } gain_word_t;

    gain_word_t  gain_words_due[$];
    gain_word_t  oldest_word;

    mode_t       cur_mode;
    logic [15:0] fix_kp;
    logic [15:0] fix_ki;
    logic [15:0] fix_kd;
    logic [15:0] hst_kp;
    logic [15:0] hst_ki;
    logic [15:0] hst_kd;
    logic        hst_ok;

    logic [15:0] act_kp;
    logic [15:0] act_ki;
    logic [15:0] act_kd;
    logic [31:0] base_err;
    logic        retrain_flag;

    function automatic int bound_gain(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    function automatic logic [15:0] move_gain(input int cur, input int tgt, input int step,
                                              input int lo, input int hi);
        int r;
        r = tgt;
        if (tgt > cur + step)
        begin
            r = cur + step;
        end
        else if (tgt < cur - step)
        begin
            r = cur - step;
        end
        return 16'(bound_gain(r, lo, hi));
    endfunction

    function automatic logic in_fixed_mode();
        return (cur_mode != MODE_FUZZY) && (cur_mode != MODE_LEARN);
    endfunction

    task automatic load_fixed_gains;
        act_kp = 16'(bound_gain(int'(fix_kp), int'(KP_MIN), int'(KP_MAX)));
        act_ki = 16'(bound_gain(int'(fix_ki), int'(KID_MIN), int'(KID_MAX)));
        act_kd = 16'(bound_gain(int'(fix_kd), int'(KID_MIN), int'(KID_MAX)));
    endtask

    task automatic apply_reg_write;
        case (cfg_index)
            CFG_TUNE_MODE:  cur_mode = mode_t'(cfg_data[1:0]);
            CFG_FIXED_KP:
            begin
                fix_kp = cfg_data;
                if (in_fixed_mode())
                begin
                    load_fixed_gains();
                end
            end
            CFG_FIXED_KI:
            begin
                fix_ki = cfg_data;
                if (in_fixed_mode())
                begin
                    load_fixed_gains();
                end
            end
            CFG_FIXED_KD:
            begin
                fix_kd = cfg_data;
                if (in_fixed_mode())
                begin
                    load_fixed_gains();
                end
            end
            CFG_HOST_KP:    hst_kp = cfg_data;
            CFG_HOST_KI:    hst_ki = cfg_data;
            CFG_HOST_KD:    hst_kd = cfg_data;
            CFG_HOST_VALID: hst_ok = cfg_data[0];
            default:        ;
        endcase
    endtask

    task automatic predict_gains;
        int         tkp;
        int         tki;
        int         tkd;
        int         skp;
        int         ski;
        int         skd;
        logic [63:0] b;
        logic [63:0] e;
        gain_word_t w;
        if (clear_retrain)
        begin
            retrain_flag = 1'b0;
        end
        if (cur_mode == MODE_FUZZY || (cur_mode == MODE_LEARN && !hst_ok))
        begin
            tkp = int'(fuzzy_kp);
            tki = int'(fuzzy_ki);
            tkd = int'(fuzzy_kd);
        end
        else if (cur_mode == MODE_LEARN)
        begin
            tkp = int'(hst_kp);
            tki = int'(hst_ki);
            tkd = int'(hst_kd);
        end
        else
        begin
            tkp = int'(fix_kp);
            tki = int'(fix_ki);
            tkd = int'(fix_kd);
        end
        tkp = bound_gain(tkp, int'(KP_MIN), int'(KP_MAX));
        tki = bound_gain(tki, int'(KID_MIN), int'(KID_MAX));
        tkd = bound_gain(tkd, int'(KID_MIN), int'(KID_MAX));
        skp = (int'(KP_RATE) * int'(time_step)) >>> 16;
        ski = (int'(KI_RATE) * int'(time_step)) >>> 16;
        skd = (int'(KD_RATE) * int'(time_step)) >>> 16;
        act_kp = move_gain(int'(act_kp), tkp, skp, int'(KP_MIN), int'(KP_MAX));
        act_ki = move_gain(int'(act_ki), tki, ski, int'(KID_MIN), int'(KID_MAX));
        act_kd = move_gain(int'(act_kd), tkd, skd, int'(KID_MIN), int'(KID_MAX));
        if (perf_valid)
        begin
            b = {32'd0, base_err};
            e = {32'd0, window_ise};
            if (b == 0 && e > 0 && settled)
            begin
                base_err = window_ise;
            end
            else if (b > 0 && e * 20 < b * 17)
            begin
                base_err = window_ise;
            end
            else if (b > 0 && e * 5 > b * 6)
            begin
                retrain_flag = 1'b1;
            end
        end
        w.kp       = act_kp;
        w.ki       = act_ki[14:0];
        w.kd       = act_kd[14:0];
        w.retrain  = retrain_flag;
        w.baseline = base_err;
        gain_words_due.push_back(w);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode     = MODE_FIXED;
            fix_kp       = '0;
            fix_ki       = '0;
            fix_kd       = '0;
            hst_kp       = '0;
            hst_ki       = '0;
            hst_kd       = '0;
            hst_ok       = 1'b0;
            act_kp       = '0;
            act_ki       = '0;
            act_kd       = '0;
            base_err     = '0;
            retrain_flag = 1'b0;
            gain_words_due.delete();
            fail_count   = 0;
            checked      = 0;
            pending      = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (gain_words_due.size() == 0)
                begin
                    $display("%0t ns: result word arrived with no prediction waiting", $time);
                    fail_count++;
                end
                else
                begin
                    oldest_word = gain_words_due.pop_front();
                    check_field("gain_kp", 32'(oldest_word.kp), 32'(gain_kp));
                    check_field("gain_ki", 32'(oldest_word.ki), 32'(gain_ki));
                    check_field("gain_kd", 32'(oldest_word.kd), 32'(gain_kd));
                    check_field("retrain_request", 32'(oldest_word.retrain),
                                32'(retrain_request));
                    check_field("baseline_ise", oldest_word.baseline, baseline_ise);
                    checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_reg_write();
            end
            if (in_valid && in_ready)
            begin
                predict_gains();
            end
            pending = gain_words_due.size();
        end
    end

endmodule

// ----- verif/tb_pid_gain_slew_scheduler.sv -----
// Testbench top for the PID gain slew scheduler: stimulus, handshake pressure and verdict.
`timescale 1ns / 100ps

module tb_pid_gain_slew_scheduler;

    import pgs_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [15:0]          fuzzy_kp = '0;
    logic [15:0]          fuzzy_ki = '0;
    logic [15:0]          fuzzy_kd = '0;
    logic [15:0]          time_step = '0;
    logic                 perf_valid = 1'b0;
    logic [31:0]          window_ise = '0;
    logic                 settled = 1'b0;
    logic                 clear_retrain = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [15:0]          gain_kp;
    logic [14:0]          gain_ki;
    logic [14:0]          gain_kd;
    logic                 retrain_request;
    logic [31:0]          baseline_ise;

    int                   fail_count;
    int                   pending;
    int                   checked;
    int                   snd_idle = 29;
    int                   rcv_idle = 75;

    pid_gain_slew_scheduler DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .fuzzy_kp        (fuzzy_kp),
        .fuzzy_ki        (fuzzy_ki),
        .fuzzy_kd        (fuzzy_kd),
        .time_step       (time_step),
        .perf_valid      (perf_valid),
        .window_ise      (window_ise),
        .settled         (settled),
        .clear_retrain   (clear_retrain),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .gain_kp         (gain_kp),
        .gain_ki         (gain_ki),
        .gain_kd         (gain_kd),
        .retrain_request (retrain_request),
        .baseline_ise    (baseline_ise)
    );

    pgs_gain_checker gain_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .fuzzy_kp        (fuzzy_kp),
        .fuzzy_ki        (fuzzy_ki),
        .fuzzy_kd        (fuzzy_kd),
        .time_step       (time_step),
        .perf_valid      (perf_valid),
        .window_ise      (window_ise),
        .settled         (settled),
        .clear_retrain   (clear_retrain),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .gain_kp         (gain_kp),
        .gain_ki         (gain_ki),
        .gain_kd         (gain_kd),
        .retrain_request (retrain_request),
        .baseline_ise    (baseline_ise),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked         (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic send_word(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [15:0] dt,
                             input logic pv, input logic [31:0] ise,
                             input logic st, input logic clr);
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        fuzzy_kp      <= kp;
        fuzzy_ki      <= ki;
        fuzzy_kd      <= kd;
        time_step     <= dt;
        perf_valid    <= pv;
        window_ise    <= ise;
        settled       <= st;
        clear_retrain <= clr;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained;
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain(input int top_val);
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0:       return 16'($urandom_range(0, 65535));
            1:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            2:       return 16'(top_val - 2 + $urandom_range(0, 4));
            3:       return 16'(int'(KP_MIN) - 2 + $urandom_range(0, 4));
            default: return 16'($urandom_range(0, top_val));
        endcase
    endfunction

    function automatic logic [31:0] pick_ise(input logic [31:0] base);
        logic [63:0] b;
        logic [63:0] r;
        int          sel;
        b   = {32'd0, base};
        sel = $urandom_range(0, 9);
        if (base == 0 && sel >= 2 && sel <= 6)
        begin
            sel = 8;
        end
        case (sel)
            0: r = 0;
            1: r = {32'd0, $urandom};
            2:
            begin
                r = (b * 17) / 20;
                if (r != 0)
                begin
                    r = r - 1;
                end
            end
            3: r = (b * 17) / 20 + $urandom_range(0, 1);
            4: r = (b * 6) / 5 + $urandom_range(0, 1);
            5: r = (b * 6) / 5 + $urandom_range(2, 1000);
            6: r = (b * 9) / 10 + $urandom_range(0, 32'(b / 5));
            7: r = 64'hFFFF_FFFF;
            8: r = $urandom_range(1, 65536);
            default: r = b;
        endcase
        if (r > 64'hFFFF_FFFF)
        begin
            r = 64'hFFFF_FFFF;
        end
        return r[31:0];
    endfunction

    task automatic send_random_word;
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [15:0] dt;
        int          sel;
        kp  = pick_gain(int'(KP_MAX));
        ki  = pick_gain(int'(KID_MAX));
        kd  = pick_gain(int'(KID_MAX));
        sel = $urandom_range(0, 9);
        case (sel)
            0:       dt = 16'h0000;
            1:       dt = 16'hFFFF;
            2, 3:    dt = 16'($urandom_range(0, 4000));
            default: dt = 16'($urandom_range(0, 65535));
        endcase
        send_word(kp, ki, kd, dt, ($urandom_range(0, 9) < 8), pick_ise(baseline_ise),
                  ($urandom_range(0, 9) < 7), ($urandom_range(0, 9) == 0));
    endtask

    task automatic apply_setting(input int kind);
        logic [15:0] vals [8];
        logic        mode_last;
        mode_last = 1'b0;
        if (kind == 0)
        begin
            foreach (vals[i])
            begin
                vals[i] = 16'hFFFF;
            end
        end
        else if (kind == 1)
        begin
            foreach (vals[i])
            begin
                vals[i] = 16'h0000;
            end
            vals[0] = 16'(MODE_LEARN);
            vals[7] = 16'h0001;
        end
        else
        begin
            vals[0]   = 16'($urandom_range(0, 65535));
            vals[1]   = pick_gain(int'(KP_MAX));
            vals[2]   = pick_gain(int'(KID_MAX));
            vals[3]   = pick_gain(int'(KID_MAX));
            vals[4]   = pick_gain(int'(KP_MAX));
            vals[5]   = pick_gain(int'(KID_MAX));
            vals[6]   = pick_gain(int'(KID_MAX));
            vals[7]   = 16'($urandom_range(0, 65535));
            mode_last = ($urandom_range(0, 1) != 0);
        end
        if (!mode_last)
        begin
            write_reg(CFG_TUNE_MODE, vals[0]);
        end
        write_reg(CFG_FIXED_KP, vals[1]);
        write_reg(CFG_FIXED_KI, vals[2]);
        write_reg(CFG_FIXED_KD, vals[3]);
        write_reg(CFG_HOST_KP, vals[4]);
        write_reg(CFG_HOST_KI, vals[5]);
        write_reg(CFG_HOST_KD, vals[6]);
        write_reg(CFG_HOST_VALID, vals[7]);
        if (mode_last)
        begin
            write_reg(CFG_TUNE_MODE, vals[0]);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(CFG_IDX_W'($urandom_range(8, 15)), 16'($urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        #(5_000_000);
        $display("pid_gain_slew_scheduler verification failed");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset state in fixed mode.
        send_word(16'd0, 16'd0, 16'd0, 16'd1, 1'b0, 32'd0, 1'b0, 1'b0);
        send_word(16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1, 32'd5000, 1'b0, 1'b0);
        send_word(16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1, 32'd0, 1'b1, 1'b0);
        send_word(16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1, 32'd100000, 1'b1, 1'b0);
        wait_drained();
        write_reg(CFG_FIXED_KP, 16'hFFFF);
        write_reg(CFG_FIXED_KI, 16'hFFFF);
        write_reg(CFG_FIXED_KD, 16'h0000);
        send_word(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 32'd120001, 1'b0, 1'b0);
        send_word(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 32'd120000, 1'b0, 1'b1);
        send_word(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 32'd85000, 1'b1, 1'b0);
        send_word(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 32'd84999, 1'b1, 1'b0);
        send_word(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        wait_drained();
        write_reg(CFG_TUNE_MODE, 16'(MODE_FIXED_ALT));
        write_reg(CFG_FIXED_KD, 16'd16385);
        write_reg(CFG_IDX_W'(15), 16'hFFFF);
        write_reg(CFG_IDX_W'(8), 16'h5555);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_TUNE_MODE, 16'(MODE_FUZZY));
        write_reg(CFG_FIXED_KP, 16'h0000);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0);
        send_word(16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0);
        send_word(16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_TUNE_MODE, 16'(MODE_LEARN));
        write_reg(CFG_HOST_VALID, 16'hFFFE);
        write_reg(CFG_HOST_KP, 16'd49152);
        write_reg(CFG_HOST_KI, 16'd16384);
        write_reg(CFG_HOST_KD, 16'd16384);
        send_word(16'd1000, 16'd1000, 16'd1000, 16'h8000, 1'b0, 32'd0, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_HOST_VALID, 16'hFFFF);
        send_word(16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0);
        send_word(16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_TUNE_MODE, 16'hFFFC);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0);

        for (int p = 0; p < 3; p++)
        begin
            if (p == 1)
            begin
                snd_idle = 75;
                rcv_idle <= 29;
            end
            else if (p == 2)
            begin
                snd_idle = 0;
                rcv_idle <= 0;
            end
            for (int s = 0; s < 4; s++)
            begin
                wait_drained();
                apply_setting(p * 4 + s);
                repeat (120) send_random_word();
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        $display("Summary: %0d result words checked over directed cases and 12 register", checked);
        $display("settings in all four modes, under three handshake pressure profiles.");
        if (fail_count == 0)
        begin
            $display("pid_gain_slew_scheduler verification clean");
        end
        else
        begin
            $display("pid_gain_slew_scheduler verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/pgs_pkg.sv
design/pid_gain_slew_scheduler.sv
design/pgs_checker.sv
verif/pgs_gain_checker.sv
verif/tb_pid_gain_slew_scheduler.sv
